[hw/rtl/rhf_pkg.sv]
// ----------------------------------------------------------------------------
// rhf_pkg
// Types, register codes and fixed-point helpers for the rod heat FTCS stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package rhf_pkg;

    // data formats
    localparam int TEMP_W = 32;                     // signed Q16.16
    localparam int COEF_W = 24;                     // unsigned Q0.24
    localparam int FRAC_W = 24;                     // coefficient fraction bits
    localparam int DIFF_W = TEMP_W + 2;             // stencil difference
    localparam int PROD_W = COEF_W + 1 + DIFF_W;    // signed product
    localparam int ACC_W  = 60;                     // accumulator, holds every sum
    localparam int Q_W    = ACC_W - FRAC_W;

    // apb register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int RIDX_W = 3;

    localparam logic [RIDX_W-1:0] REG_FOURIER = 3'd0;
    localparam logic [RIDX_W-1:0] REG_CONV    = 3'd1;
    localparam logic [RIDX_W-1:0] REG_AMBIENT = 3'd2;
    localparam logic [RIDX_W-1:0] REG_WALL    = 3'd3;
    localparam logic [RIDX_W-1:0] REG_START   = 3'd4;

    // register reset values
    localparam logic        [COEF_W-1:0] FOURIER_RST = 24'd8389;
    localparam logic        [COEF_W-1:0] CONV_RST    = 24'd16777;
    localparam logic signed [TEMP_W-1:0] AMBIENT_RST = 32'sd6553600;
    localparam logic signed [TEMP_W-1:0] WALL_RST    = 32'sd1310720;
    localparam logic signed [TEMP_W-1:0] START_RST   = 32'sd1310720;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0]    Q_MAX    = Q_W'(TEMP_MAX);
    localparam logic signed [Q_W-1:0]    Q_MIN    = Q_W'(TEMP_MIN);
    localparam logic signed [ACC_W-1:0]  HALF_LSB = ACC_W'(1) << (FRAC_W - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PRIME = 8'b0000_0010,
        ST_MULF  = 8'b0000_0100,
        ST_ADDF  = 8'b0000_1000,
        ST_MULC  = 8'b0001_0000,
        ST_ADDC  = 8'b0010_0000,
        ST_WRITE = 8'b0100_0000,
        ST_FILL  = 8'b1000_0000
    } state_t;

    // round to nearest (ties up) after dropping the coefficient fraction, then clamp
    function automatic logic signed [TEMP_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] a;
        logic signed [Q_W-1:0]   q;
        a = acc + HALF_LSB;
        q = a[ACC_W-1:FRAC_W];
        if (q > Q_MAX) begin
            return TEMP_MAX;
        end else if (q < Q_MIN) begin
            return TEMP_MIN;
        end else begin
            return TEMP_W'(q);
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rod_heat_ftcs_step.sv]
// ----------------------------------------------------------------------------
// rod_heat_ftcs_step
// Explicit FTCS heat step over a rod of NODES nodes with a shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted item either reloads every node with start_temp (restart) or
// advances all nodes by one explicit step from the old values; with emit set,
// every node is then reported in order, node 0 first, last flagged. In a step
// the nodes are walked one at a time through a single 25x34 multiplier and a
// node memory with one read and one write port: the read window is primed
// first, the wall node is written then, each later node is multiplied, added
// and written, and the last node adds a multiply and an add for the
// convective term; a result held up at the output stalls the walk. A restart
// without emit is done on its accept. After reset every node holds 20.0
// (Q16.16); registers sit on a small APB port at byte offsets 4*i.
`default_nettype none

module rod_heat_ftcs_step
    import rhf_pkg::*;
#(
    parameter int NODES = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // item input
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_restart,
    input  wire logic                      s_emit,
    // result output
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [3:0]                     m_node_index,
    output logic signed [TEMP_W-1:0]       m_temperature,
    output logic                           m_last,
    // register port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    localparam int IDX_W = $clog2(NODES);
    localparam int IDX_X = (IDX_W > 4) ? IDX_W : 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
    localparam logic [IDX_W:0]   NODES_X  = (IDX_W + 1)'(NODES);
    localparam logic [3:0]       LAST_IDX4 = 4'(NODES - 1);

    // configuration registers
    logic        [COEF_W-1:0] fourier_reg;
    logic        [COEF_W-1:0] conv_reg;
    logic signed [TEMP_W-1:0] ambient_reg;
    logic signed [TEMP_W-1:0] wall_reg;
    logic signed [TEMP_W-1:0] start_reg;

    // sequencer
    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg;
    logic                     emit_reg;

    // node store; unwritten entries read as the last restart value
    logic signed [TEMP_W-1:0] mem [NODES];
    logic [NODES-1:0]         valid_reg;
    logic signed [TEMP_W-1:0] fill_reg;
    logic signed [TEMP_W-1:0] rd_data_reg;
    logic                     rd_valid_reg;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;

    // stencil window and arithmetic
    logic signed [TEMP_W-1:0] prev_reg;
    logic signed [TEMP_W-1:0] cur_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // output register
    logic                     m_valid_reg;
    logic [3:0]               m_node_index_reg;
    logic signed [TEMP_W-1:0] m_temperature_reg;
    logic                     m_last_reg;

    logic                     accept;
    logic                     out_free;
    logic                     idx_last;
    logic [IDX_W:0]           idx_plus2;
    logic [IDX_X-1:0]         idx_ext;
    logic                     wr_go;
    logic                     out_load;
    logic signed [TEMP_W-1:0] wr_data;
    logic signed [TEMP_W-1:0] rd_val;
    logic signed [DIFF_W-1:0] d_prev, d_cur, d_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [COEF_W:0]   mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_base;
    logic                     cfg_wr;
    logic [RIDX_W-1:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fourier_reg <= FOURIER_RST;
            conv_reg    <= CONV_RST;
            ambient_reg <= AMBIENT_RST;
            wall_reg    <= WALL_RST;
            start_reg   <= START_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FOURIER: fourier_reg <= pwdata[COEF_W-1:0];
                REG_CONV:    conv_reg    <= pwdata[COEF_W-1:0];
                REG_AMBIENT: ambient_reg <= $signed(pwdata[TEMP_W-1:0]);
                REG_WALL:    wall_reg    <= $signed(pwdata[TEMP_W-1:0]);
                REG_START:   start_reg   <= $signed(pwdata[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FOURIER: prdata = DATA_W'(fourier_reg);
            REG_CONV:    prdata = DATA_W'(conv_reg);
            REG_AMBIENT: prdata = ambient_reg;
            REG_WALL:    prdata = wall_reg;
            REG_START:   prdata = start_reg;
            default:     prdata = '0;
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_last  = (idx_reg == LAST_IDX);
    assign idx_plus2 = {1'b0, idx_reg} + (IDX_W + 1)'(2);
    assign idx_ext   = IDX_X'(idx_reg);
    assign rd_val    = rd_valid_reg ? rd_data_reg : fill_reg;

    assign wr_go    = (state_reg == ST_WRITE) && (!emit_reg || out_free);
    assign out_load = (wr_go && emit_reg) || ((state_reg == ST_FILL) && out_free);
    assign wr_data  = (idx_reg == '0) ? wall_reg : round_sat(acc_reg);

    // read window: the read data register holds the old value of node idx+1
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept && !s_restart) begin
            rd_en = 1'b1;
        end else if (state_reg == ST_PRIME) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(1);
        end else if (wr_go && !idx_last && (idx_plus2 < NODES_X)) begin
            rd_en   = 1'b1;
            rd_addr = idx_plus2[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_go) begin
            mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= START_RST;
        end else if (accept && s_restart) begin
            valid_reg <= '0;
            fill_reg  <= start_reg;
        end else if (wr_go) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // shared multiplier operands
    assign d_prev = DIFF_W'(prev_reg);
    assign d_cur  = DIFF_W'(cur_reg);
    assign d_next = DIFF_W'(rd_val);

    always_comb begin
        // node 1 mirrors the wall, the last node mirrors its neighbor
        if (idx_last || (idx_reg == IDX_W'(1))) begin
            diff = (d_prev <<< 1) - (d_cur <<< 1);
        end else begin
            diff = d_prev + d_next - (d_cur <<< 1);
        end
    end

    always_comb begin
        if (state_reg == ST_MULC) begin
            mul_a = {1'b0, conv_reg};
            mul_b = DIFF_W'(ambient_reg) - d_cur;
        end else begin
            mul_a = {1'b0, fourier_reg};
            mul_b = diff;
        end
    end

    assign prod     = mul_a * mul_b;
    assign acc_base = (state_reg == ST_ADDC) ? acc_reg : (ACC_W'(cur_reg) <<< FRAC_W);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MULF || state_reg == ST_MULC) begin
            prod_reg <= prod;
        end
        if (state_reg == ST_ADDF || state_reg == ST_ADDC) begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
        end
        if (state_reg == ST_PRIME) begin
            cur_reg <= rd_val;
        end else if (wr_go) begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_val;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_restart) begin
                        state_next = ST_PRIME;
                    end else if (s_emit) begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_PRIME: state_next = ST_WRITE;
            ST_MULF:  state_next = ST_ADDF;
            ST_ADDF:  state_next = idx_last ? ST_MULC : ST_WRITE;
            ST_MULC:  state_next = ST_ADDC;
            ST_ADDC:  state_next = ST_WRITE;
            ST_WRITE: begin
                if (wr_go) begin
                    state_next = idx_last ? ST_IDLE : ST_MULF;
                end
            end
            ST_FILL: begin
                if (out_free && idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            emit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                idx_reg  <= '0;
                emit_reg <= s_emit;
            end else if ((wr_go || ((state_reg == ST_FILL) && out_free)) && !idx_last) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // output register holds a result until it is taken; the sequencer stalls while it waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_node_index_reg  <= idx_ext[3:0];
            m_temperature_reg <= (state_reg == ST_FILL) ? fill_reg : wr_data;
            m_last_reg        <= idx_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_node_index  = m_node_index_reg;
    assign m_temperature = m_temperature_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // a result only ever comes out of a node write or a restart run
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_WRITE || state_reg == ST_FILL))
        else $error("result item appeared outside a node write or restart run");

    // the run ends on the final node
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_node_index == LAST_IDX4))
        else $error("last flag on a node other than the final one");

    // the node walk never leaves the rod
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg <= LAST_IDX))
        else $error("node index past the end of the rod");

    // a step starts by priming the read window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_restart) |=> (state_reg == ST_PRIME && idx_reg == '0))
        else $error("step item did not start at node zero");
`endif

endmodule

`default_nettype wire
